// ===== design/serial_frame_receiver_top_defines.svh =====
// ---------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared concurrent-assertion helpers, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sfr_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial frame receiver package
// Event codes, register indexes, frame constants and the job record.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned MINLEN_W   = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CMPW       = 9;

  localparam logic [BYTE_W-1:0]   START_BYTE    = 8'h7E;
  localparam int unsigned         LEN_POS       = 10;
  localparam int unsigned         TYPE_POS      = 9;
  localparam int unsigned         LEN_EXTRA     = 12;
  localparam logic [MINLEN_W-1:0] MIN_LEN_FLOOR = 7'd11;

  localparam logic [MINLEN_W-1:0] RST_MIN_LEN  = 7'd12;
  localparam logic [7:0]          RST_TIMEOUT  = 8'd5;
  localparam logic [7:0]          RST_ACK_LOW  = 8'd0;
  localparam logic [7:0]          RST_ACK_HIGH = 8'd255;

  localparam int unsigned JOBQ_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE    = 2'd0,
    CMD_OVERRUN = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN  = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_ACK_LOW  = 2'd2,
    CFG_ACK_HIGH = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_STREAM
  } back_state_e;

  // one completed frame handed from the front to the back
  typedef struct packed {
    logic             good;
    logic             ack;
    logic [POS_W-1:0] last_pos;
  } job_t;

endpackage

// ===== design/serial_frame_receiver_top.sv =====
// ---------------------------------------------------------------------------
// Serial frame receiver
// Deframes UART bytes: start byte, length byte, mod-256 checksum trailer.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata                                     | tuser     | tlast
//  ---------+-----+-------------------------------------------+-----------+------
//  s_axis   | in  | [7:0] rx_byte                             | [1:0] cmd | -
//  m_axis   | out | [7:0] frame_byte, [13:8] byte_pos, [14] ack | [0] status | last
//  cfg      | in  | cfg_we_i / cfg_idx_i / cfg_wdata_i, one write per cycle
//
// The front end handles each event beat as it is accepted. A beat that ends a frame queues
// a job; a good job is popped and the buffer read before the output loads (an error job
// loads directly), then one beat per cycle as m_axis_tready allows, paced by buffer reads.
// Hold input while a job is queued or streaming: the back end reads the buffer that
// the front end writes. The output register frees the input once the final beat is loaded.
// Reset is asynchronous, active low; the buffer itself needs no clearing.
//
module serial_frame_receiver_top #(
  parameter int unsigned FRAME_BUFFER_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // event stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]                     s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_pos,
                                                         // [14] ack_seen, [15] zero
  output logic [0:0]                     m_axis_tuser,   // [0] status
  output logic                           m_axis_tlast
);
  import sfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BUFFER_DEPTH);

  logic              accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              push, pop, q_empty, back_idle;
  job_t              job_in, job_out;
  logic              status;
  logic [BYTE_W-1:0] frame_byte;
  logic [POS_W-1:0]  byte_pos;
  logic              ack_seen;

  // hold input while a frame job is pending anywhere in the back end
  assign s_axis_tready = q_empty && back_idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfr_front #(
    .DEPTH (FRAME_BUFFER_DEPTH),
    .AW    (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .job_o       (job_in)
  );

  sfr_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (q_empty)
  );

  sfr_back #(
    .DEPTH (FRAME_BUFFER_DEPTH),
    .AW    (AW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .q_empty_i (q_empty),
    .job_i     (job_out),
    .pop_o     (pop),
    .idle_o    (back_idle),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_o  (status),
    .byte_o    (frame_byte),
    .pos_o     (byte_pos),
    .last_o    (m_axis_tlast),
    .ack_o     (ack_seen)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {1'b0, ack_seen, byte_pos, frame_byte};
  assign m_axis_tuser = status;

endmodule

// ===== design/sfr_front.sv =====
// ---------------------------------------------------------------------------
// Serial frame receiver front end
// Classifies events, keeps index, sum and idle timer, writes the buffer.
// ---------------------------------------------------------------------------
`include "serial_frame_receiver_top_defines.svh"

module sfr_front #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [sfr_pkg::CMD_W-1:0]     cmd_i,
  input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic [sfr_pkg::BYTE_W-1:0]    wr_data_o,
  output logic                          push_o,
  output sfr_pkg::job_t                 job_o
);
  import sfr_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH + 1);

  logic [MINLEN_W-1:0] min_len_q;
  logic [7:0]          timeout_q, ack_low_q, ack_high_q;
  logic [IW-1:0]       idx_q, idx_d;
  logic [BYTE_W-1:0]   sum_q, sum_d;
  logic [7:0]          cd_q, cd_d;
  logic                run_q, run_d;
  logic [BYTE_W-1:0]   type_q, len_q;

  logic [IW-1:0]       idx_base, idx_new;
  logic [BYTE_W-1:0]   sum_base, len_cur;
  logic [MINLEN_W-1:0] min_len;
  logic                done;
  cmd_e                cmd;

  assign cmd      = cmd_e'(cmd_i);
  assign idx_base = (idx_q >= IW'(DEPTH)) ? '0 : idx_q;
  assign sum_base = (idx_q >= IW'(DEPTH)) ? '0 : sum_q;
  assign idx_new  = idx_base + IW'(1);
  assign len_cur  = (idx_base == IW'(LEN_POS)) ? rx_byte_i : len_q;
  assign min_len  = (min_len_q < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_q;
  assign done     = (CMPW'(idx_new) >= CMPW'(min_len)) &&
                    (CMPW'(idx_new) == CMPW'(len_cur) + CMPW'(LEN_EXTRA));

  assign wr_en_o   = accept_i && (cmd == CMD_BYTE);
  assign wr_addr_o = idx_base[AW-1:0];
  assign wr_data_o = rx_byte_i;

  always_comb begin
    idx_d          = idx_q;
    sum_d          = sum_q;
    cd_d           = cd_q;
    run_d          = run_q;
    push_o         = 1'b0;
    job_o.good     = (sum_base == rx_byte_i);
    job_o.ack      = (type_q > ack_low_q) && (type_q < ack_high_q);
    job_o.last_pos = POS_W'(idx_base);
    if (accept_i) begin
      case (cmd)
        CMD_OVERRUN: begin
          idx_d = '0;
          sum_d = '0;
        end
        CMD_TICK: begin
          if (run_q) begin
            if (cd_q <= 8'd1) begin
              cd_d  = '0;
              run_d = 1'b0;
              idx_d = '0;
              sum_d = '0;
            end else begin
              cd_d = cd_q - 8'd1;
            end
          end
        end
        CMD_BYTE: begin
          cd_d  = timeout_q;
          run_d = 1'b1;
          idx_d = idx_new;
          sum_d = sum_base + rx_byte_i;
          if (idx_base == '0 && rx_byte_i != START_BYTE) begin
            idx_d = '0;
            sum_d = '0;
          end else if (done) begin
            run_d  = 1'b0;
            cd_d   = '0;
            idx_d  = '0;
            sum_d  = '0;
            push_o = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= RST_MIN_LEN;
      timeout_q  <= RST_TIMEOUT;
      ack_low_q  <= RST_ACK_LOW;
      ack_high_q <= RST_ACK_HIGH;
      idx_q      <= '0;
      sum_q      <= '0;
      cd_q       <= '0;
      run_q      <= 1'b0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      cd_q  <= cd_d;
      run_q <= run_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_LEN:  min_len_q  <= cfg_wdata_i[MINLEN_W-1:0];
          CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
          CFG_ACK_LOW:  ack_low_q  <= cfg_wdata_i;
          CFG_ACK_HIGH: ack_high_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // capture type and length bytes of the frame in progress
  always_ff @(posedge clk_i) begin
    if (wr_en_o && idx_base == IW'(TYPE_POS)) type_q <= rx_byte_i;
    if (wr_en_o && idx_base == IW'(LEN_POS))  len_q  <= rx_byte_i;
  end

  `SFR_ASSERT_NEXT(a_push_clears, push_o, idx_q == '0 && sum_q == '0 && !run_q, "frame not cleared")
  `SFR_ASSERT_NOW(a_push_on_byte, push_o, wr_en_o && idx_base >= IW'(LEN_POS), "bad push")

endmodule

// ===== design/sfr_jobq.sv =====
// ---------------------------------------------------------------------------
// Serial frame receiver job queue
// Short FIFO of completed-frame records between front and back.
// ---------------------------------------------------------------------------
module sfr_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::job_t job_i,
  input  logic          pop_i,
  output sfr_pkg::job_t job_o,
  output logic          empty_o
);
  import sfr_pkg::*;

  localparam int unsigned PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(JOBQ_DEPTH + 1);

  job_t          ent_q [JOBQ_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign job_o   = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(JOBQ_DEPTH - 1)) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_q <= (rp_q == PW'(JOBQ_DEPTH - 1)) ? '0 : rp_q + PW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= job_i;
  end

endmodule

// ===== design/sfr_back.sv =====
// ---------------------------------------------------------------------------
// Serial frame receiver back end
// Holds the frame buffer, replays good frames, reports checksum errors.
// ---------------------------------------------------------------------------
`include "serial_frame_receiver_top_defines.svh"

module sfr_back #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [sfr_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                       q_empty_i,
  input  sfr_pkg::job_t              job_i,
  output logic                       pop_o,
  output logic                       idle_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic                       status_o,
  output logic [sfr_pkg::BYTE_W-1:0] byte_o,
  output logic [sfr_pkg::POS_W-1:0]  pos_o,
  output logic                       last_o,
  output logic                       ack_o
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  back_state_e       state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d, pos_nxt, last_pos_q;
  logic              ack_q;
  logic              can_load, load;
  logic              ld_status, ld_last, ld_ack;
  logic [BYTE_W-1:0] ld_byte;
  logic [POS_W-1:0]  ld_pos;
  logic              m_valid_q;

  assign can_load  = !m_valid_q || m_ready_i;
  assign pos_nxt   = pos_q + POS_W'(1);
  assign idle_o    = (state_q == BK_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = pos_nxt[AW-1:0];
    load      = 1'b0;
    ld_status = 1'b0;
    ld_byte   = rd_data_q;
    ld_pos    = pos_q;
    ld_last   = (pos_q == last_pos_q);
    ld_ack    = ack_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (!job_i.good) begin
            if (can_load) begin
              pop_o     = 1'b1;
              load      = 1'b1;
              ld_status = 1'b1;
              ld_byte   = '0;
              ld_pos    = '0;
              ld_last   = 1'b1;
              ld_ack    = 1'b0;
            end
          end else begin
            pop_o   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = '0;
            pos_d   = '0;
            state_d = BK_STREAM;
          end
        end
      end
      BK_STREAM: begin
        if (can_load) begin
          load = 1'b1;
          if (pos_q == last_pos_q) begin
            state_d = BK_IDLE;
          end else begin
            rd_en = 1'b1;
            pos_d = pos_nxt;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load)           m_valid_q <= 1'b1;
      else if (m_ready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (pop_o && job_i.good) begin
      last_pos_q <= job_i.last_pos;
      ack_q      <= job_i.ack;
    end
    if (load) begin
      status_o <= ld_status;
      byte_o   <= ld_byte;
      pos_o    <= ld_pos;
      last_o   <= ld_last;
      ack_o    <= ld_ack;
    end
  end

  // frame buffer: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en)   rd_data_q <= mem[rd_addr];
  end

  `SFR_ASSERT_NOW(a_no_pop_streaming, state_q == BK_STREAM, !pop_o, "pop while streaming")
  `SFR_ASSERT_NOW(a_no_write_busy, wr_en_i, state_q == BK_IDLE && q_empty_i, "buffer write while busy")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Streams byte, overrun, tick and unused events into the deframer. Random
// stalls and a long output hold-off are applied. An in-bench frame predictor
// checks every result beat field by field, over five register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import sfr_pkg::*;

  localparam int unsigned FRAME_DEPTH  = 64;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam longint      LIMIT_CYCLES = 2_500_000;

  // one result beat, as the predictor expects it and the monitor sees it
  typedef struct packed {
    logic             status;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_pos;
    logic             is_last;
    logic             ack_seen;
  } rx_result_t;

  // --------------------------------------------------------------------------
  // Frame predictor and result store
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [MINLEN_W-1:0] min_len;
    logic [7:0]          timeout_ticks;
    logic [7:0]          ack_lo;
    logic [7:0]          ack_hi;
    logic [7:0]          frame_mem [FRAME_DEPTH];
    int unsigned         wr_idx;
    logic [7:0]          csum;
    logic [7:0]          countdown;
    bit                  timer_on;
    rx_result_t          expected_q [$];
    int unsigned         n_errors;
    int unsigned         n_checked;
    int unsigned         n_good_frames;
    int unsigned         n_bad_frames;

    function new();
      min_len       = RST_MIN_LEN;
      timeout_ticks = RST_TIMEOUT;
      ack_lo        = RST_ACK_LOW;
      ack_hi        = RST_ACK_HIGH;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      wr_idx        = 0;
      csum          = '0;
      countdown     = '0;
      timer_on      = 1'b0;
      n_errors      = 0;
      n_checked     = 0;
      n_good_frames = 0;
      n_bad_frames  = 0;
    endfunction

    // advance the receiver state by one accepted event, queue what it yields
    function void note_event(cmd_e c, logic [7:0] b);
      int unsigned need;
      logic [7:0]  sum_prev;
      logic        ack;
      rx_result_t  r;
      case (c)
        CMD_OVERRUN: begin
          wr_idx = 0;
          csum   = '0;
        end
        CMD_TICK: begin
          if (timer_on) begin
            if (countdown <= 8'd1) begin
              countdown = '0;
              timer_on  = 1'b0;
              wr_idx    = 0;
              csum      = '0;
            end else begin
              countdown--;
            end
          end
        end
        CMD_BYTE: begin
          countdown = timeout_ticks;
          timer_on  = 1'b1;
          // full buffer: restart before storing
          if (wr_idx >= FRAME_DEPTH) begin
            wr_idx = 0;
            csum   = '0;
          end
          sum_prev = csum;
          need = (min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len;
          frame_mem[wr_idx] = b;
          wr_idx++;
          csum += b;
          if (wr_idx == 1 && b != START_BYTE) begin
            wr_idx = 0;
            csum   = '0;
          end else if (wr_idx >= need && wr_idx == frame_mem[LEN_POS] + LEN_EXTRA) begin
            timer_on  = 1'b0;
            countdown = '0;
            if (sum_prev == b) begin
              ack = (frame_mem[TYPE_POS] > ack_lo) && (frame_mem[TYPE_POS] < ack_hi);
              for (int i = 0; i < wr_idx; i++) begin
                r.status     = 1'b0;
                r.frame_byte = frame_mem[i];
                r.byte_pos   = POS_W'(i);
                r.is_last    = (i + 1 == wr_idx);
                r.ack_seen   = ack;
                expected_q.push_back(r);
              end
              n_good_frames++;
            end else begin
              r = '0;
              r.status  = 1'b1;
              r.is_last = 1'b1;
              expected_q.push_back(r);
              n_bad_frames++;
            end
            wr_idx = 0;
            csum   = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      n_errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_beat(rx_result_t got);
      rx_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: %p", got));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, want %b", got.status, want.status));
      if (got.frame_byte !== want.frame_byte)
        report_mismatch($sformatf("frame_byte %h, want %h", got.frame_byte, want.frame_byte));
      if (got.byte_pos !== want.byte_pos)
        report_mismatch($sformatf("byte_pos %0d, want %0d", got.byte_pos, want.byte_pos));
      if (got.is_last !== want.is_last)
        report_mismatch($sformatf("last %b, want %b (pos %0d)", got.is_last, want.is_last,
                                  want.byte_pos));
      if (got.ack_seen !== want.ack_seen)
        report_mismatch($sformatf("ack_seen %b, want %b", got.ack_seen, want.ack_seen));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block hookup
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  frame_scoreboard sb = new();

  bit          no_idle         = 1'b0;  // suppress random gaps on both sides
  int unsigned hold_off_cycles = 0;     // request a long output hold-off
  bit          sink_holding    = 1'b0;
  int unsigned n_data          = 0;     // byte and overrun beats sent
  int unsigned n_settings      = 1;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  serial_frame_receiver_top #(
    .FRAME_BUFFER_DEPTH(FRAME_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Result side: ready pattern and beat monitor
  // --------------------------------------------------------------------------
  // Each pass drives ready once and then waits on the clock, so the
  // signal never sees two updates in the same step.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        // long hold-off: let the block back up into its input
        sink_holding = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
        sink_holding    = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Sample the result beat at the edge where it is taken.
  always @(posedge clk_i) begin : result_monitor
    rx_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = m_axis_tuser[0];
      got.frame_byte = m_axis_tdata[7:0];
      got.byte_pos   = m_axis_tdata[13:8];
      got.ack_seen   = m_axis_tdata[14];
      got.is_last    = m_axis_tlast;
      sb.check_beat(got);
    end
  end

  // --------------------------------------------------------------------------
  // Event side drivers
  // --------------------------------------------------------------------------
  // Offer one event beat; hold it until taken, then note it in the predictor.
  // Valid stays high after the beat so back-to-back beats need no new edge.
  task automatic send_event(cmd_e c, logic [7:0] b);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(c, b);
    if (c == CMD_BYTE || c == CMD_OVERRUN) n_data++;
  endtask

  // Write all four registers back to back while the block is quiet.
  task automatic program_regs(logic [MINLEN_W-1:0] mlen, logic [7:0] tmo,
                              logic [7:0] lo, logic [7:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MIN_LEN;
    cfg_wdata_i <= CFG_DATA_W'(mlen);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ACK_LOW;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ACK_HIGH;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.min_len       = mlen;
    sb.timeout_ticks = tmo;
    sb.ack_lo        = lo;
    sb.ack_hi        = hi;
    n_settings++;
  endtask

  // Drop valid, wait for every expected beat, then let the pipe go quiet.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Type byte: mostly right at the edges of the ack window.
  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 5))
      0:       return sb.ack_lo;
      1:       return sb.ack_lo + 8'd1;
      2:       return sb.ack_hi - 8'd1;
      3:       return sb.ack_hi;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Frame length: mostly short, now and then anything up to the buffer size.
  function automatic int unsigned pick_len();
    int unsigned lo;
    int unsigned n;
    lo = (sb.min_len > LEN_EXTRA) ? sb.min_len : LEN_EXTRA;
    if ($urandom_range(0, 6) == 0) return $urandom_range(lo, FRAME_DEPTH);
    n = lo + $urandom_range(0, 8);
    return (n > FRAME_DEPTH) ? FRAME_DEPTH : n;
  endfunction

  // Send a well-formed frame of n bytes; corrupt the trailer unless good_sum.
  task automatic send_frame(int unsigned n, bit good_sum);
    logic [7:0] fb [FRAME_DEPTH];
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < n - 1; i++) begin
      if (i == 0)             fb[i] = START_BYTE;
      else if (i == LEN_POS)  fb[i] = 8'(n - LEN_EXTRA);
      else if (i == TYPE_POS) fb[i] = pick_type();
      else                    fb[i] = 8'($urandom_range(0, 255));
      sum += fb[i];
    end
    fb[n-1] = good_sum ? sum : sum ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < n; i++) begin
      // an occasional tick between bytes, short of the timeout
      if (sb.timeout_ticks > 2 && $urandom_range(0, 19) == 0)
        send_event(CMD_TICK, 8'($urandom_range(0, 255)));
      send_event(CMD_BYTE, fb[i]);
    end
  endtask

  // Bring the write index back to zero: time out or overrun.
  task automatic resync();
    if (sb.wr_idx == 0) return;
    if (sb.timer_on && sb.countdown <= 8 && $urandom_range(0, 3) == 0) begin
      while (sb.timer_on) send_event(CMD_TICK, 8'($urandom_range(0, 255)));
    end else begin
      send_event(CMD_OVERRUN, 8'($urandom_range(0, 255)));
    end
  endtask

  // Random mix: mostly clean frames, plus noise, broken frames and ticks.
  task automatic random_traffic(int unsigned budget);
    int unsigned start;
    int unsigned sel;
    int unsigned k;
    start = n_data;
    while (n_data - start < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        resync();
        send_frame(pick_len(), $urandom_range(0, 4) != 0);
      end else if (sel < 75) begin
        k = $urandom_range(1, 6);
        repeat (k) send_event(cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (sel < 90) begin
        // partial frame, too short to complete, then cut it off
        resync();
        k = $urandom_range(1, 10);
        send_event(CMD_BYTE, START_BYTE);
        repeat (k - 1) send_event(CMD_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) begin
          send_event(CMD_OVERRUN, 8'($urandom_range(0, 255)));
        end else if (sb.countdown <= 8) begin
          while (sb.timer_on) send_event(CMD_TICK, 8'($urandom_range(0, 255)));
        end
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) send_event(CMD_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values. Open with the corner events:
    // wrong start byte, unused code, clean frame, timeout, overrun, bad sum.
    send_event(CMD_BYTE, 8'h00);
    send_event(CMD_UNUSED, 8'hFF);
    send_frame(12, 1'b1);
    send_event(CMD_BYTE, START_BYTE);
    repeat (RST_TIMEOUT) send_event(CMD_TICK, 8'($urandom_range(0, 255)));
    send_event(CMD_BYTE, START_BYTE);
    send_event(CMD_OVERRUN, 8'h00);
    send_frame(12, 1'b0);
    random_traffic(20);
    drain_results();

    // Shortest frame floor, one-tick timeout, empty ack window.
    // Overfill the buffer once with a length byte that never matches.
    program_regs(7'd11, 8'd1, 8'd255, 8'd0);
    resync();
    for (int i = 0; i < FRAME_DEPTH + 3; i++) begin
      if (i == 0)
        send_event(CMD_BYTE, START_BYTE);
      else if (i == LEN_POS)
        send_event(CMD_BYTE, 8'($urandom_range(FRAME_DEPTH - LEN_EXTRA + 1, 255)));
      else
        send_event(CMD_BYTE, 8'($urandom_range(0, 255)));
    end
    random_traffic(10);
    drain_results();

    // Only full-buffer frames complete; a short frame just piles up.
    program_regs(7'd64, 8'd255, 8'h40, 8'h80);
    resync();
    send_frame(FRAME_DEPTH, 1'b1);
    send_frame(12, 1'b1);
    drain_results();

    // Hold the result side off for a long stretch while frames keep coming,
    // so the block backs up and stalls its input.
    program_regs(7'd20, 8'd3, 8'd9, 8'd11);
    resync();
    s_axis_tvalid <= 1'b0;
    hold_off_cycles = 400;
    wait (sink_holding);
    send_frame(20, 1'b1);
    send_frame(24, 1'b1);
    send_frame(20, 1'b0);
    random_traffic(15);
    drain_results();

    // Closing stretch without any gaps on either side.
    no_idle = 1'b1;
    program_regs(7'd12, 8'd8, 8'd1, 8'd254);
    resync();
    random_traffic(20);
    drain_results();

    $display("covered %0d byte/overrun beats under %0d register settings", n_data, n_settings);
    $display("frames: %0d good, %0d checksum errors; %0d result beats checked",
             sb.n_good_frames, sb.n_bad_frames, sb.n_checked);
    if (sb.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("watchdog expired with %0d beats still expected", sb.expected_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
